// File: design/text_console_cell_writer_core_assert.svh
// Assertion macros shared by the console writer modules.
`ifndef TEXT_CONSOLE_CELL_WRITER_CORE_ASSERT_SVH
`define TEXT_CONSOLE_CELL_WRITER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TCCW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tccw: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TCCW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tccw: next-cycle check failed");

`endif

// File: design/tccw_pkg.sv
// Types and constants of the text console cell writer.
`default_nettype none

package tccw_pkg;

    localparam int CELL_INDEX_W    = 11;
    localparam int CELL_VALUE_W    = 16;
    localparam int CURSOR_ROW_W    = 5;
    localparam int CURSOR_COL_W    = 7;

    localparam logic [7:0] CH_BS         = 8'h08;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_FIRST_PRINT = 8'h20;
    localparam logic [7:0] CH_LAST_PRINT  = 8'h7F;

    localparam logic [CELL_VALUE_W-1:0] BLANK_CELL = 16'h0F20;
    localparam int TAB_STOP = 8;

    localparam logic FUNC_PUT   = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] char_code;
        logic [3:0] bg_color;
        logic [3:0] fg_color;
    } in_item_t;

    typedef struct packed {
        logic                    cell_written;
        logic [CELL_INDEX_W-1:0] cell_index;
        logic [CELL_VALUE_W-1:0] cell_value;
        logic                    scrolled;
        logic [CELL_INDEX_W-1:0] cursor_offset;
        logic [CURSOR_ROW_W-1:0] cursor_row;
        logic [CURSOR_COL_W-1:0] cursor_col;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_STEP,
        ST_SCROLL,
        ST_CLEAR
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic commit;
        logic sweep_restart;
        logic sweep_run;
        logic sweep_fill;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic is_clear;
        logic will_scroll;
        logic sweep_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// File: design/tccw_chan_if.sv
// Valid/ready channel carrying one payload item per transfer.
`default_nettype none

interface tccw_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: design/tccw_ctrl.sv
// Sequencing state machine of the console writer.
`default_nettype none
`include "text_console_cell_writer_core_assert.svh"

module tccw_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_accept,
    input  wire tccw_pkg::sts_t sts,
    output tccw_pkg::cmd_t     cmd,
    output logic               item_ready
);

    tccw_pkg::state_t state_reg;
    tccw_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tccw_pkg::ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            tccw_pkg::ST_INIT:
            begin
                cmd.sweep_run  = 1'b1;
                cmd.sweep_fill = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = tccw_pkg::ST_IDLE;
                end
            end
            tccw_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = tccw_pkg::ST_STEP;
                end
            end
            tccw_pkg::ST_STEP:
            begin
                if (sts.out_free)
                begin
                    cmd.commit        = 1'b1;
                    cmd.sweep_restart = 1'b1;
                    if (sts.is_clear)
                    begin
                        state_next = tccw_pkg::ST_CLEAR;
                    end
                    else if (sts.will_scroll)
                    begin
                        state_next = tccw_pkg::ST_SCROLL;
                    end
                    else
                    begin
                        state_next = tccw_pkg::ST_IDLE;
                    end
                end
            end
            tccw_pkg::ST_SCROLL:
            begin
                cmd.sweep_run = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = tccw_pkg::ST_IDLE;
                end
            end
            tccw_pkg::ST_CLEAR:
            begin
                cmd.sweep_run  = 1'b1;
                cmd.sweep_fill = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = tccw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tccw_pkg::ST_INIT;
            end
        endcase
    end

    `TCCW_ASSERT_NEXT(a_accept_then_step, item_accept, state_reg == tccw_pkg::ST_STEP)

endmodule

`default_nettype wire

// File: design/tccw_datapath.sv
// Cursor arithmetic, cell store with sweep engine, and result register.
`default_nettype none
`include "text_console_cell_writer_core_assert.svh"

module tccw_datapath #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tccw_pkg::cmd_t     cmd,
    input  wire tccw_pkg::in_item_t item_in,
    input  wire logic               result_ready,
    output tccw_pkg::sts_t          sts,
    output logic                    result_valid,
    output tccw_pkg::out_item_t     result_out
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'((ROWS - 1) * COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_CELL     = ADDR_W'(CELLS - 1);
    localparam logic [COL_W:0]    TAB_MASK      = ~((COL_W + 1)'(tccw_pkg::TAB_STOP - 1));
    localparam logic [COL_W:0]    COL_LIMIT     = (COL_W + 1)'(COLUMNS);
    localparam logic [ROW_W:0]    ROW_LIMIT     = (ROW_W + 1)'(ROWS);
    localparam logic [ROW_W:0]    ROW_LAST      = (ROW_W + 1)'(ROWS - 1);

    tccw_pkg::in_item_t item_reg;
    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;

    logic [COL_W:0]     col_next;
    logic [ROW_W:0]     row_next;
    logic               written;
    logic               scroll;
    logic [ADDR_W-1:0]  cell_addr;
    logic [ADDR_W-1:0]  offset;
    logic [15:0]        cell_data;

    logic [tccw_pkg::CELL_VALUE_W-1:0] mem [CELLS];
    logic [ADDR_W-1:0]  ptr_reg;
    logic [ADDR_W-1:0]  wr_addr_reg;
    logic               wr_pending_reg;
    logic               wr_blank_reg;
    logic [tccw_pkg::CELL_VALUE_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]  rd_addr;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [tccw_pkg::CELL_VALUE_W-1:0] mem_wdata;

    logic                out_valid_reg;
    tccw_pkg::out_item_t out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item_in;
        end
    end

    // Next cursor position for the held item.
    always_comb
    begin
        col_next = {1'b0, col_reg};
        row_next = {1'b0, row_reg};
        written  = 1'b0;
        scroll   = 1'b0;
        if (item_reg.func == tccw_pkg::FUNC_CLEAR)
        begin
            col_next = '0;
            row_next = '0;
        end
        else
        begin
            unique case (item_reg.char_code) inside
                tccw_pkg::CH_BS:
                begin
                    if (col_reg != '0)
                    begin
                        col_next = {1'b0, col_reg} - (COL_W + 1)'(1);
                    end
                end
                tccw_pkg::CH_TAB:
                begin
                    col_next = ({1'b0, col_reg} + (COL_W + 1)'(tccw_pkg::TAB_STOP)) & TAB_MASK;
                end
                tccw_pkg::CH_CR:
                begin
                    col_next = '0;
                end
                tccw_pkg::CH_LF:
                begin
                    col_next = '0;
                    row_next = {1'b0, row_reg} + (ROW_W + 1)'(1);
                end
                [tccw_pkg::CH_FIRST_PRINT:tccw_pkg::CH_LAST_PRINT]:
                begin
                    written  = 1'b1;
                    col_next = {1'b0, col_reg} + (COL_W + 1)'(1);
                end
                default:
                begin
                    written = 1'b0;
                end
            endcase
            if (col_next >= COL_LIMIT)
            begin
                col_next = '0;
                row_next = row_next + (ROW_W + 1)'(1);
            end
            if (row_next >= ROW_LIMIT)
            begin
                scroll   = 1'b1;
                row_next = ROW_LAST;
            end
        end
    end

    assign cell_addr = ADDR_W'(row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(col_reg);
    assign offset    = ADDR_W'(row_next) * ADDR_W'(COLUMNS) + ADDR_W'(col_next);
    assign cell_data = {item_reg.bg_color, item_reg.fg_color, item_reg.char_code};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cmd.commit)
        begin
            col_reg <= col_next[COL_W-1:0];
            row_reg <= row_next[ROW_W-1:0];
        end
    end

    // Sweep engine: issue a read ahead, write the cell in the next cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg        <= '0;
            wr_pending_reg <= 1'b0;
        end
        else
        begin
            wr_pending_reg <= cmd.sweep_run;
            if (cmd.sweep_restart)
            begin
                ptr_reg <= '0;
            end
            else if (cmd.sweep_run)
            begin
                ptr_reg <= ptr_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg  <= ptr_reg;
        wr_blank_reg <= cmd.sweep_fill || (ptr_reg >= LAST_ROW_BASE);
    end

    assign rd_addr = (ptr_reg >= LAST_ROW_BASE) ? ptr_reg : ptr_reg + ADDR_W'(COLUMNS);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cell_addr;
        mem_wdata = cell_data;
        if (wr_pending_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = wr_addr_reg;
            mem_wdata = wr_blank_reg ? tccw_pkg::BLANK_CELL : rd_data_reg;
        end
        else if (cmd.commit && written)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_reg.cell_written  <= written;
            out_reg.cell_index    <= written ? tccw_pkg::CELL_INDEX_W'(cell_addr) : '0;
            out_reg.cell_value    <= written ? cell_data : '0;
            out_reg.scrolled      <= scroll;
            out_reg.cursor_offset <= tccw_pkg::CELL_INDEX_W'(offset);
            out_reg.cursor_row    <= tccw_pkg::CURSOR_ROW_W'(row_next);
            out_reg.cursor_col    <= tccw_pkg::CURSOR_COL_W'(col_next);
        end
    end

    assign result_valid    = out_valid_reg;
    assign result_out      = out_reg;
    assign sts.is_clear    = (item_reg.func == tccw_pkg::FUNC_CLEAR);
    assign sts.will_scroll = scroll;
    assign sts.sweep_last  = (ptr_reg == LAST_CELL);
    assign sts.out_free    = !out_valid_reg || result_ready;

    `TCCW_ASSERT_NOW(a_commit_has_slot, cmd.commit, sts.out_free)
    `TCCW_ASSERT_NOW(a_no_write_clash, wr_pending_reg, !cmd.commit)
    `TCCW_ASSERT_NEXT(a_clear_homes, cmd.commit && sts.is_clear, row_reg == '0 && col_reg == '0)

endmodule

`default_nettype wire

// File: design/text_console_cell_writer_core.sv
// Top level of the text console cell writer.
`default_nettype none

// Text-mode console writer. Each transfer on item carries either a character
// byte with 4-bit background and foreground colors (func = 0) or a clear
// command (func = 1). Printable bytes 0x20..0x7F are stored at the cursor as
// {back, fore, char} and advance it; backspace, tab (next multiple of 8),
// carriage return and line feed move the cursor; other bytes change nothing.
// A full line wraps, and moving past the last row scrolls the store up one
// row and blanks the bottom row with white-on-black spaces. Every item yields
// exactly one transfer on result carrying the stored cell (if any) and the
// new cursor row, column and offset row*COLUMNS+column.
// Sequence: an item is taken in ST_IDLE; ST_STEP then updates the cursor,
// writes the cell and loads the result register once that register is free;
// the result register lets the next item be taken while a result still waits.
// A scroll or a clear then walks the whole cell store through its single
// write port, one cell per cycle, with item held off. After reset the store
// is filled with blanks the same way before the first item is taken.
module text_console_cell_writer_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input wire logic clk,
    input wire logic rst_n,
    tccw_chan_if.sink   item,
    tccw_chan_if.source result
);

    tccw_pkg::cmd_t      cmd;
    tccw_pkg::sts_t      sts;
    tccw_pkg::in_item_t  item_payload;
    tccw_pkg::out_item_t result_payload;
    logic                item_ready;
    logic                item_accept;
    logic                result_valid;

    assign item_payload = item.payload;
    assign item_accept  = item.valid && item_ready;
    assign item.ready   = item_ready;

    // Sequence item intake, cell update and store sweeps.
    tccw_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_accept (item_accept),
        .sts         (sts),
        .cmd         (cmd),
        .item_ready  (item_ready)
    );

    // Hold cursor, cell store and result register.
    tccw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .item_in      (item_payload),
        .result_ready (result.ready),
        .sts          (sts),
        .result_valid (result_valid),
        .result_out   (result_payload)
    );

    assign result.valid   = result_valid;
    assign result.payload = result_payload;

endmodule

`default_nettype wire

// File: dv/testbench.sv
// Testbench for the text console cell writer: cursor tracking scoreboard and drivers.
`timescale 1ns / 100ps

module testbench;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int CLK_HALF    = 4;
    localparam int RESET_CYCLES = 8;
    // A scroll or a clear walks the whole store with item held off. Allow that
    // plus long receiver stalls several times over.
    localparam int QUIET_LIMIT = 20000;
    // Cycles to keep watching for a stray result once all results are in.
    localparam int DRAIN_CYCLES = COLUMNS * ROWS + 100;
    localparam int PHASE_ITEMS = 100;

    // Track the console cursor and queue the result that every item must
    // produce. The cell store itself is never visible at the ports, so only
    // the cursor is tracked; stored cells are checked as they are reported.
    class console_tracker;
        int row;
        int col;
        tccw_pkg::out_item_t pending_results[$];
        int fail_count;
        int items_seen;
        int results_seen;
        int cells_stored;
        int scroll_count;
        int clear_count;

        function new();
            row = 0;
            col = 0;
            fail_count = 0;
            items_seen = 0;
            results_seen = 0;
            cells_stored = 0;
            scroll_count = 0;
            clear_count = 0;
        endfunction

        // Note an accepted item: advance the cursor and queue its result.
        function void take_item(tccw_pkg::in_item_t it);
            tccw_pkg::out_item_t r;
            r = '0;
            items_seen++;
            if (it.func == tccw_pkg::FUNC_CLEAR)
            begin
                row = 0;
                col = 0;
                clear_count++;
            end
            else
            begin
                if (it.char_code == tccw_pkg::CH_BS && col != 0)
                    col--;
                else if (it.char_code == tccw_pkg::CH_TAB)
                    col = (col + tccw_pkg::TAB_STOP) & ~(tccw_pkg::TAB_STOP - 1);
                else if (it.char_code == tccw_pkg::CH_CR)
                    col = 0;
                else if (it.char_code == tccw_pkg::CH_LF)
                begin
                    col = 0;
                    row++;
                end
                else if (it.char_code >= tccw_pkg::CH_FIRST_PRINT &&
                         it.char_code <= tccw_pkg::CH_LAST_PRINT)
                begin
                    // Index is taken at the old cursor, before any scroll.
                    r.cell_written = 1'b1;
                    r.cell_index = tccw_pkg::CELL_INDEX_W'(row * COLUMNS + col);
                    r.cell_value = {it.bg_color, it.fg_color, it.char_code};
                    cells_stored++;
                    col++;
                end
                if (col >= COLUMNS)
                begin
                    col = 0;
                    row++;
                end
                if (row >= ROWS)
                begin
                    row = ROWS - 1;
                    r.scrolled = 1'b1;
                    scroll_count++;
                end
            end
            r.cursor_offset = tccw_pkg::CELL_INDEX_W'(row * COLUMNS + col);
            r.cursor_row = tccw_pkg::CURSOR_ROW_W'(row);
            r.cursor_col = tccw_pkg::CURSOR_COL_W'(col);
            pending_results.push_back(r);
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $display("%0t: result %0d field %s expected 0x%0h actual 0x%0h",
                         $time, results_seen, name, want, got);
                fail_count++;
            end
        endfunction

        // Compare an accepted result with the oldest queued one.
        function void match_result(tccw_pkg::out_item_t got);
            tccw_pkg::out_item_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with no item outstanding, expected none actual 0x%0h",
                         $time, got);
                fail_count++;
                return;
            end
            want = pending_results.pop_front();
            results_seen++;
            check_field("cell_written", 16'(want.cell_written), 16'(got.cell_written));
            check_field("cell_index", 16'(want.cell_index), 16'(got.cell_index));
            check_field("cell_value", want.cell_value, got.cell_value);
            check_field("scrolled", 16'(want.scrolled), 16'(got.scrolled));
            check_field("cursor_offset", 16'(want.cursor_offset), 16'(got.cursor_offset));
            check_field("cursor_row", 16'(want.cursor_row), 16'(got.cursor_row));
            check_field("cursor_col", 16'(want.cursor_col), 16'(got.cursor_col));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    tccw_chan_if #(.payload_t(tccw_pkg::in_item_t))  item_if ();
    tccw_chan_if #(.payload_t(tccw_pkg::out_item_t)) result_if ();

    text_console_cell_writer_core #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_if.sink),
        .result(result_if.source)
    );

    console_tracker tracker;
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;
    int active_items;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    // Stall the result side at random; change ready only at the falling edge.
    always @(negedge clk)
    begin
        result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Sample both channels at the rising edge. Reading here sees the values
    // that stood at the edge, before any register in the block updates.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_if.valid && item_if.ready)
                tracker.take_item(item_if.payload);
            if (result_if.valid && result_if.ready)
                tracker.match_result(result_if.payload);
            if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
        end
    end

    // End the run if nothing moves for too long.
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(negedge clk);
        $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic tccw_pkg::in_item_t make_put(logic [7:0] ch, logic [3:0] back,
                                                    logic [3:0] fore);
        tccw_pkg::in_item_t it;
        it.func = tccw_pkg::FUNC_PUT;
        it.char_code = ch;
        it.bg_color = back;
        it.fg_color = fore;
        return it;
    endfunction

    function automatic tccw_pkg::in_item_t make_clear();
        tccw_pkg::in_item_t it;
        it.func = tccw_pkg::FUNC_CLEAR;
        it.char_code = 8'($urandom_range(255));
        it.bg_color = 4'($urandom_range(15));
        it.fg_color = 4'($urandom_range(15));
        return it;
    endfunction

    function automatic tccw_pkg::in_item_t rand_put(logic [7:0] ch);
        return make_put(ch, 4'($urandom_range(15)), 4'($urandom_range(15)));
    endfunction

    // Offer one item, idling first as the sender phase asks, and hold it
    // until the transfer. Return at the falling edge after the transfer.
    task automatic send_item(tccw_pkg::in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_if.valid <= 1'b0;
            @(negedge clk);
        end
        item_if.valid <= 1'b1;
        item_if.payload <= it;
        do
            @(posedge clk);
        while (!item_if.ready);
        @(negedge clk);
        // Bytes that change nothing do not count toward the random quota.
        if (it.func == tccw_pkg::FUNC_CLEAR || it.char_code == tccw_pkg::CH_BS ||
            it.char_code == tccw_pkg::CH_TAB ||
            it.char_code == tccw_pkg::CH_CR || it.char_code == tccw_pkg::CH_LF ||
            (it.char_code >= tccw_pkg::CH_FIRST_PRINT &&
             it.char_code <= tccw_pkg::CH_LAST_PRINT))
            active_items++;
    endtask

    // Send a line of text: mostly printable bytes with some cursor moves,
    // sometimes long enough to wrap, ended by a newline most of the time.
    task automatic send_line();
        int len;
        int pick;
        if ($urandom_range(9) == 0)
            len = $urandom_range(120, 60);
        else
            len = $urandom_range(20, 1);
        repeat (len)
        begin
            pick = $urandom_range(99);
            if (pick < 85)
                send_item(rand_put(8'($urandom_range(8'h7F, 8'h20))));
            else if (pick < 93)
                send_item(rand_put(tccw_pkg::CH_BS));
            else
                send_item(rand_put(tccw_pkg::CH_TAB));
        end
        pick = $urandom_range(3);
        if (pick == 0)
            send_item(rand_put(tccw_pkg::CH_CR));
        if (pick <= 1)
            send_item(rand_put(tccw_pkg::CH_LF));
        else if (pick == 2)
            send_item(rand_put(tccw_pkg::CH_LF));
    endtask

    // Random bytes outside the printable range: controls, some of which move the cursor, and high bytes.
    task automatic send_noise();
        logic [7:0] ch;
        if ($urandom_range(1) == 0)
            ch = 8'($urandom_range(8'hFF, 8'h80));
        else
            ch = 8'($urandom_range(8'h1F, 8'h00));
        send_item(rand_put(ch));
    endtask

    task automatic run_random(int quota);
        int target;
        int pick;
        target = active_items + quota;
        while (active_items < target)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
                send_line();
            else if (pick < 78)
                repeat ($urandom_range(12, 1)) send_item(rand_put(tccw_pkg::CH_LF));
            else if (pick < 97)
                send_noise();
            else
                send_item(make_clear());
        end
    endtask

    initial
    begin
        tracker = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        active_items = 0;
        rst_n = 1'b0;
        item_if.valid = 1'b0;
        item_if.payload = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, no idling on either side.
        send_item(make_put(tccw_pkg::CH_BS, 4'h0, 4'h0));   // backspace at column zero
        send_item(make_put(8'h20, 4'h0, 4'h0));       // lowest printable, colors zero
        send_item(make_put(8'h7F, 4'hF, 4'hF));       // highest printable, colors full
        send_item(make_put(tccw_pkg::CH_BS, 4'h3, 4'hC));   // backspace from column two
        send_item(make_put(8'h00, 4'hF, 4'h0));       // ignored bytes from here
        send_item(make_put(8'hFF, 4'h0, 4'hF));
        send_item(make_put(8'h80, 4'hA, 4'h5));
        send_item(make_put(8'h1F, 4'h5, 4'hA));
        send_item(make_put(tccw_pkg::CH_CR, 4'h0, 4'h0));
        // Tab across the whole line; the tenth wraps to the next row.
        repeat (10) send_item(make_put(tccw_pkg::CH_TAB, 4'h1, 4'h2));
        send_item(make_put(tccw_pkg::CH_LF, 4'h0, 4'h0));
        send_item(make_put(8'h41, 4'h5, 4'hA));
        send_item(make_put(8'h55, 4'hA, 4'h5));
        send_item(make_clear());
        send_item(make_put(8'h2A, 4'h7, 4'h8));

        // Random part, one idling pattern per phase.
        run_random(PHASE_ITEMS);
        send_idle_pct = 84;
        run_random(PHASE_ITEMS);
        send_idle_pct = 0;
        recv_stall_pct = 84;
        run_random(PHASE_ITEMS);
        send_idle_pct = 19;
        recv_stall_pct = 19;
        run_random(PHASE_ITEMS);
        item_if.valid <= 1'b0;

        // Wait for every result, then watch a while longer for strays.
        while (tracker.pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d items (%0d cells stored, %0d scrolls, %0d clears)",
                 tracker.items_seen, tracker.cells_stored, tracker.scroll_count,
                 tracker.clear_count);
        $display("Checked %0d results across four idling phases, %0d mismatches",
                 tracker.results_seen, tracker.fail_count);
        if (tracker.fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/tccw_pkg.sv
design/tccw_chan_if.sv
design/tccw_ctrl.sv
design/tccw_datapath.sv
design/text_console_cell_writer_core.sv
dv/testbench.sv
